@@ rtl/core/av1ser_pkg.sv @@
// Package for the AV1 syntax element reader: buffer sizing, operation and status codes.
// Used by av1_syntax_element_reader_unit, av1ser_checker and testbench; no dependencies.
package av1ser_pkg;
  localparam int BufferBytes = 16;
  localparam int AddrW       = $clog2(BufferBytes);
  localparam int TotalBits   = BufferBytes * 8;
  localparam int BitIdxW     = $clog2(TotalBits);
  localparam int FillW       = $clog2(TotalBits + 1);

  localparam logic [2:0] OpPush  = 3'd0;
  localparam logic [2:0] OpF     = 3'd1;
  localparam logic [2:0] OpSu    = 3'd2;
  localparam logic [2:0] OpLe    = 3'd3;
  localparam logic [2:0] OpNs    = 3'd4;
  localparam logic [2:0] OpUvlc  = 3'd5;
  localparam logic [2:0] OpLeb   = 3'd6;
  localparam logic [2:0] OpAlign = 3'd7;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMore = 2'd1;
  localparam logic [1:0] StSize = 2'd2;
  localparam logic [1:0] StOver = 2'd3;
endpackage

@@ rtl/core/av1ser_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module av1ser_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/av1_syntax_element_reader_unit.sv @@
// Top level of the AV1 syntax element reader: byte FIFO in a RAM and a bit-serial decoder.
// Depends on av1ser_pkg and av1ser_ram.
//
// Usage: pulse start_i with operation_i, size_i and data_byte_i while busy_o is low.
// One beat per command: the result appears on value_o, status_o and buffered_bits_o
// for a single cycle marked by done_o. The receiver cannot stall, so the result
// must be captured in that cycle.
// Every command passes through a check state and a finish state; the result beat follows
// in the next cycle, in which busy_o is already low and a new command may be taken.
// Push, byte align, bad-size results, need-more results found by the checks, f(0),
// le(0) and ns with one symbol therefore go straight from the check to the finish state.
// Other reads walk the buffered bits one bit per cycle through the byte RAM, but pause
// at each byte touched for a fetch state and a wait state (address and registered read).
// f(64), le(8) and an 8-byte leb128 walk 64 bits over up to 9 bytes. uvlc walks its
// leading zeros too, so a full buffer of zeros walks all 128 bits over all 16 bytes,
// the longest case.
// Reads never modify the RAM; the read pointer and fill count move only on success.
// Reset clears the pointers and fill count; the RAM needs no clearing since
// only written entries are ever read.
// Rate: one command at a time, limited by the bit walk over the single RAM read port.
module av1_syntax_element_reader_unit
  import av1ser_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] size_i,
  input  logic [7:0]  data_byte_i,
  output logic        done_o,
  output logic [63:0] value_o,
  output logic [1:0]  status_o,
  output logic [7:0]  buffered_bits_o
);
  typedef enum logic [2:0] {
    SIdle, SCheck, SFetch, SWait, SBit, SDone
  } state_e;

  state_e              state_q;
  logic [2:0]          op_q;
  logic [31:0]         size_q;
  logic [7:0]          dbyte_q;
  logic [BitIdxW-1:0]  rd_q;
  logic [AddrW-1:0]    wr_q;
  logic [FillW-1:0]    fill_q;
  logic [BitIdxW-1:0]  pos_q;   // current bit position of the walk
  logic [FillW-1:0]    used_q;  // bits consumed so far in the walk
  logic [FillW-1:0]    need_q;  // bits to take in the current phase
  logic [7:0]          sh_q;    // byte being shifted out
  logic [2:0]          bpos_q;
  logic [63:0]         acc_q;
  logic [63:0]         aux_q;   // ns threshold / le byte / leb byte
  logic [5:0]          lz_q;
  logic [2:0]          cnt_q;   // byte counter for le/leb
  logic [1:0]          phase_q;
  logic [6:0]          nw_q;    // ns width
  logic [63:0]         value_q;
  logic [1:0]          status_q;
  logic                done_q;

  logic                ram_we;
  logic [7:0]          ram_rdata;

  av1ser_ram #(.Width(8), .Depth(BufferBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (dbyte_q),
    .raddr_i (pos_q[BitIdxW-1:3]),
    .rdata_o (ram_rdata)
  );

  assign busy_o          = (state_q != SIdle);
  assign done_o          = done_q;
  assign value_o         = value_q;
  assign status_o        = status_q;
  assign buffered_bits_o = 8'(fill_q);
  assign ram_we          = (state_q == SCheck) && (op_q == OpPush) &&
                           (fill_q <= FillW'(TotalBits - 8));

  // Bit width of the ns alphabet size.
  logic [6:0] ns_w;
  always_comb begin
    ns_w = 7'd0;
    for (int i = 0; i < 32; i++) if (size_q[i]) ns_w = 7'(i + 1);
  end

  logic bit_c;
  assign bit_c = sh_q[7];

  // Sequencer: check, then walk bits through the RAM one per cycle, pausing per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      rd_q     <= '0;
      wr_q     <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
      status_q <= StOk;
      value_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) begin
            op_q    <= operation_i;
            size_q  <= size_i;
            dbyte_q <= data_byte_i;
            state_q <= SCheck;
          end
        end
        SCheck: begin
          acc_q   <= '0;
          aux_q   <= '0;
          used_q  <= '0;
          lz_q    <= '0;
          cnt_q   <= '0;
          phase_q <= 2'd0;
          pos_q   <= rd_q;
          nw_q    <= ns_w;
          value_q <= '0;
          status_q <= StOk;
          state_q <= SDone;
          case (op_q)
            OpPush: begin
              if (fill_q > FillW'(TotalBits - 8)) status_q <= StOver;
              else begin
                wr_q   <= wr_q + 1'b1;
                fill_q <= fill_q + FillW'(8);
              end
            end
            OpF, OpSu: begin
              if (size_q > 32'd64 || (op_q == OpSu && size_q == 32'd0)) status_q <= StSize;
              else if (size_q > 32'(fill_q)) status_q <= StMore;
              else if (size_q != 32'd0) begin
                need_q <= FillW'(size_q);
                state_q <= SFetch;
              end
            end
            OpLe: begin
              if (size_q > 32'd8) status_q <= StSize;
              else if ({size_q[28:0], 3'b000} > 32'(fill_q)) status_q <= StMore;
              else if (size_q != 32'd0) begin
                need_q <= FillW'(8);
                state_q <= SFetch;
              end
            end
            OpNs: begin
              if (size_q == 32'd0) status_q <= StSize;
              else if (32'(ns_w) - 32'd1 > 32'(fill_q)) status_q <= StMore;
              else if (ns_w == 7'd1) begin
                // Alphabet of one symbol: no bits.
              end else begin
                aux_q  <= (64'd1 << ns_w) - {32'd0, size_q};
                need_q <= FillW'(ns_w - 7'd1);
                state_q <= SFetch;
              end
            end
            OpUvlc: begin
              if (fill_q == '0) status_q <= StMore;
              else begin
                need_q <= fill_q;
                state_q <= SFetch;
              end
            end
            OpLeb: begin
              if (fill_q < FillW'(8)) status_q <= StMore;
              else begin
                need_q <= FillW'(8);
                state_q <= SFetch;
              end
            end
            default: begin
              if (rd_q[2:0] != 3'd0) begin
                rd_q   <= rd_q + BitIdxW'(4'd8 - {1'b0, rd_q[2:0]});
                fill_q <= fill_q - FillW'(4'd8 - {1'b0, rd_q[2:0]});
              end
            end
          endcase
        end
        SFetch: state_q <= SWait;
        SWait: begin
          sh_q    <= ram_rdata << pos_q[2:0];
          bpos_q  <= pos_q[2:0];
          state_q <= SBit;
        end
        SBit: begin
          // One bit per cycle; refetch the byte at a boundary.
          logic [FillW-1:0]   used_n;
          logic [FillW-1:0]   need_n;
          logic [63:0]        acc_n;
          logic [63:0]        aux_n;
          logic [5:0]         lz_n;
          logic [2:0]         cnt_n;
          logic [1:0]         phase_n;
          logic               fin;
          logic               starved;
          used_n  = used_q + 1'b1;
          need_n  = need_q - 1'b1;
          acc_n   = acc_q;
          aux_n   = aux_q;
          lz_n    = lz_q;
          cnt_n   = cnt_q;
          phase_n = phase_q;
          fin     = 1'b0;
          starved = 1'b0;
          case (op_q)
            OpF, OpSu: begin
              acc_n = {acc_q[62:0], bit_c};
              if (need_n == '0) fin = 1'b1;
            end
            OpLe: begin
              aux_n = {aux_q[62:0], bit_c};
              if (need_n == '0) begin
                acc_n = acc_q | ({56'd0, aux_q[6:0], bit_c} << {cnt_q, 3'b000});
                cnt_n = cnt_q + 1'b1;
                if (32'(cnt_q) + 32'd1 == size_q) fin = 1'b1;
                else need_n = FillW'(8);
              end
            end
            OpNs: begin
              if (phase_q == 2'd0) begin
                acc_n = {acc_q[62:0], bit_c};
                if (need_n == '0) begin
                  if (acc_n >= aux_q) begin
                    // The extra bit must be buffered as well.
                    if (fill_q < FillW'(nw_q)) starved = 1'b1;
                    else begin
                      phase_n = 2'd1;
                      need_n  = FillW'(1);
                    end
                  end else fin = 1'b1;
                end
              end else begin
                acc_n = {acc_q[62:0], 1'b0} - aux_q + {63'd0, bit_c};
                fin = 1'b1;
              end
            end
            OpUvlc: begin
              if (phase_q == 2'd0) begin
                if (bit_c) begin
                  if (lz_q == 6'd32) begin
                    acc_n = 64'hFFFF_FFFF;
                    fin = 1'b1;
                  end else if (FillW'({lz_q, 1'b1}) > fill_q) begin
                    starved = 1'b1;
                  end else if (lz_q == 6'd0) begin
                    acc_n = '0;
                    fin = 1'b1;
                  end else begin
                    phase_n = 2'd1;
                    need_n  = FillW'(lz_q);
                  end
                end else begin
                  if (lz_q != 6'd32) lz_n = lz_q + 1'b1;
                  if (need_n == '0) starved = 1'b1;
                end
              end else begin
                acc_n = {acc_q[62:0], bit_c};
                if (need_n == '0) begin
                  acc_n = acc_n + (64'd1 << lz_q) - 64'd1;
                  fin = 1'b1;
                end
              end
            end
            default: begin
              aux_n = {aux_q[62:0], bit_c};
              if (need_n == '0) begin
                acc_n = acc_q | ({57'd0, aux_q[5:0], bit_c} << (7 * cnt_q));
                cnt_n = cnt_q + 1'b1;
                if (!aux_q[6] || cnt_q == 3'd7) fin = 1'b1;
                else if (used_n + FillW'(8) > fill_q) starved = 1'b1;
                else need_n = FillW'(8);
              end
            end
          endcase
          pos_q   <= pos_q + 1'b1;
          used_q  <= used_n;
          need_q  <= need_n;
          sh_q    <= sh_q << 1;
          bpos_q  <= bpos_q + 1'b1;
          acc_q   <= acc_n;
          aux_q   <= aux_n;
          lz_q    <= lz_n;
          cnt_q   <= cnt_n;
          phase_q <= phase_n;
          if (fin) begin
            rd_q    <= rd_q + BitIdxW'(used_n);
            fill_q  <= fill_q - used_n;
            state_q <= SDone;
          end else if (starved) begin
            status_q <= StMore;
            state_q  <= SDone;
          end else if (bpos_q == 3'd7) begin
            state_q <= SFetch;
          end
        end
        SDone: begin
          if (status_q == StOk && op_q != OpPush && op_q != OpAlign) begin
            if (op_q == OpSu && size_q < 32'd64 && acc_q[size_q[5:0] - 6'd1])
              value_q <= acc_q | (~64'd0 << size_q[5:0]);
            else value_q <= acc_q;
          end
          done_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Buffered bit count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillW'(TotalBits))
    else $error("fill count above capacity");
  // A result beat always ends a command and returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> state_q == SIdle)
    else $error("result beat while busy");
  // A non-ok result carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_q && status_q != StOk |-> value_q == '0)
    else $error("value set on failed command");
  // Reads never write the RAM.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> op_q == OpPush)
    else $error("RAM write outside push");
endmodule

@@ tb/av1ser_checker.sv @@
// Result checker for the AV1 syntax element reader: mirrors the byte FIFO and bit reader,
// predicts each result beat and compares it field by field. Depends on av1ser_pkg.
`timescale 1ns / 100ps

module av1ser_checker
  import av1ser_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  operation_i,
  input  logic [31:0] size_i,
  input  logic [7:0]  data_byte_i,
  input  logic        done_i,
  input  logic [63:0] value_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  buffered_bits_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [7:0]  bits;
  } element_t;

  element_t   element_q[$];
  logic [7:0] fifo_mem [BufferBytes];
  int unsigned rd_bit;
  int unsigned wr_byte;
  int unsigned fill;

  // Bits taken MSB-first from the read position plus an offset, without consuming.
  function automatic logic [63:0] peek(input int unsigned off, input int unsigned cnt);
    logic [63:0] v;
    int unsigned pos;
    v = '0;
    for (int unsigned i = 0; i < cnt; i++) begin
      pos = (rd_bit + off + i) % TotalBits;
      v = {v[62:0], fifo_mem[(pos >> 3) % BufferBytes][7 - (pos & 7)]};
    end
    return v;
  endfunction

  function automatic void take(input int unsigned k);
    rd_bit = (rd_bit + k) % TotalBits;
    fill -= k;
  endfunction

  // Decodes one command beat against the mirrored buffer state.
  function automatic element_t decode(input logic [2:0] op, input logic [31:0] n,
                                      input logic [7:0] db);
    element_t r;
    int unsigned w, need, lz, used;
    logic [63:0] m, v, b;
    logic [31:0] t;
    bit finished;
    r = '0;
    r.status = StOk;
    case (op)
      OpPush: begin
        if (fill + 8 > TotalBits) r.status = StOver;
        else begin
          fifo_mem[wr_byte] = db;
          wr_byte = (wr_byte + 1) % BufferBytes;
          fill += 8;
        end
      end
      OpF, OpSu: begin
        if (n > 64 || (op == OpSu && n == 0)) r.status = StSize;
        else if (n > fill) r.status = StMore;
        else begin
          v = peek(0, n);
          if (op == OpSu && n < 64 && v[n-1]) v |= ~64'd0 << n;
          r.value = v;
          take(n);
        end
      end
      OpLe: begin
        if (n > 8) r.status = StSize;
        else if (n * 8 > fill) r.status = StMore;
        else begin
          for (int unsigned i = 0; i < n; i++) r.value |= peek(i * 8, 8) << (i * 8);
          take(n * 8);
        end
      end
      OpNs: begin
        if (n == 0) r.status = StSize;
        else begin
          w = 0;
          t = n;
          while (t != 0) begin
            t >>= 1;
            w++;
          end
          m = (64'd1 << w) - 64'(n);
          if (w - 1 > fill) r.status = StMore;
          else begin
            v = peek(0, w - 1);
            need = w - 1;
            if (v >= m) begin
              if (w > fill) r.status = StMore;
              else begin
                v = (v << 1) - m + peek(w - 1, 1);
                need = w;
              end
            end
            if (r.status == StOk) begin
              r.value = v;
              take(need);
            end
          end
        end
      end
      OpUvlc: begin
        lz = 0;
        while (lz < fill && peek(lz, 1) == 0) lz++;
        if (lz >= fill) r.status = StMore;
        else if (lz >= 32) begin
          r.value = 64'hFFFF_FFFF;
          take(lz + 1);
        end else if (2 * lz + 1 > fill) r.status = StMore;
        else begin
          r.value = peek(lz + 1, lz) + (64'd1 << lz) - 1;
          take(2 * lz + 1);
        end
      end
      OpLeb: begin
        used = 0;
        finished = 0;
        v = '0;
        for (int unsigned i = 0; i < 8; i++) begin
          if (used + 8 > fill) break;
          b = peek(used, 8);
          used += 8;
          v |= (b & 64'h7F) << (i * 7);
          if (!b[7] || i == 7) begin
            finished = 1;
            break;
          end
        end
        if (finished) begin
          r.value = v;
          take(used);
        end else r.status = StMore;
      end
      default: begin
        need = (8 - (rd_bit & 7)) & 7;
        if (need > fill) r.status = StMore;
        else take(need);
      end
    endcase
    r.bits = fill[7:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Command beats feed the prediction; result beats are compared with the oldest one.
  always @(posedge clk_i or negedge rst_ni) begin
    element_t want;
    if (!rst_ni) begin
      rd_bit = 0;
      wr_byte = 0;
      fill = 0;
      element_q.delete();
      fail_count_o = 0;
      results_o = 0;
      pending_o = 0;
    end else begin
      if (done_i) begin
        results_o++;
        if (element_q.size() == 0) report("unexpected result", value_i, 64'd0);
        else begin
          want = element_q.pop_front();
          if (value_i !== want.value) report("value", value_i, want.value);
          if (status_i !== want.status)
            report("status", 64'(status_i), 64'(want.status));
          if (buffered_bits_i !== want.bits)
            report("buffered bits", 64'(buffered_bits_i), 64'(want.bits));
        end
      end
      if (start_i && !busy_i) element_q.push_back(decode(operation_i, size_i, data_byte_i));
      pending_o = element_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the AV1 syntax element reader testbench: clock, reset, command stimulus and verdict.
// Depends on av1ser_pkg, av1_syntax_element_reader_unit and av1ser_checker.
`timescale 1ns / 100ps

module testbench;
  import av1ser_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic [2:0]  operation_i = OpPush;
  logic [31:0] size_i = 0;
  logic [7:0]  data_byte_i = 0;
  logic        busy_o, done_o;
  logic [63:0] value_o;
  logic [1:0]  status_o;
  logic [7:0]  buffered_bits_o;
  int          fail_count, pending, results;
  int          idle_cycles = 0;
  int          issued = 0;

  always #4 clk_i = ~clk_i;

  av1_syntax_element_reader_unit DUT (.*);

  av1ser_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .size_i, .data_byte_i,
    .done_i(done_o), .value_i(value_o), .status_i(status_o),
    .buffered_bits_i(buffered_bits_o), .fail_count_o(fail_count), .pending_o(pending),
    .results_o(results)
  );

  // Watchdog: counts cycles with no command and no result beat.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Drives one command beat, with a random gap first, and holds it until accepted.
  // Start stays high when the next beat follows without a gap.
  task automatic issue(input logic [2:0] op, input logic [31:0] n, input logic [7:0] db);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1;
    operation_i <= op;
    size_i <= n;
    data_byte_i <= db;
    do @(posedge clk_i); while (busy_o);
    issued++;
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) issue(OpPush, $urandom, 8'($urandom));
  endtask

  // Random size for a read operation, mostly legal with some out-of-range values.
  function automatic logic [31:0] pick_size(input logic [2:0] op);
    if ($urandom_range(0, 15) == 0) return $urandom;
    case (op)
      OpF, OpSu: return $urandom_range(0, 64);
      OpLe:      return $urandom_range(0, 8);
      OpNs:      return ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 300);
      default:   return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty reads, overflow, extremes and special cases.
    issue(OpF, 1, 0);
    issue(OpUvlc, 0, 0);
    issue(OpAlign, 0, 0);
    for (int i = 0; i < 17; i++) issue(OpPush, 0, (i < 5) ? 8'h00 : 8'hFF);
    issue(OpF, 0, 0);
    issue(OpSu, 0, 0);
    issue(OpF, 65, 0);
    issue(OpLe, 9, 0);
    issue(OpNs, 0, 0);
    issue(OpNs, 1, 0);
    issue(OpF, 3, 0);
    issue(OpAlign, 0, 0);
    issue(OpUvlc, 0, 0);
    issue(OpSu, 64, 0);
    issue(OpLe, 0, 0);
    issue(OpLeb, 0, 0);
    issue(OpNs, 32'hFFFF_FFFF, 0);

    // Random: mostly reads over a refilled buffer, bytes drawn from varied patterns.
    while (issued < 720) begin
      if (pending == 0 && $urandom_range(0, 3) == 0) push_random($urandom_range(1, 16));
      op = 3'($urandom_range(0, 7));
      if (op == OpPush) begin
        case ($urandom_range(0, 3))
          0: issue(OpPush, 0, 8'h00);
          1: issue(OpPush, 0, 8'h80 | 8'($urandom_range(0, 127)));
          default: issue(OpPush, $urandom, 8'($urandom));
        endcase
      end else issue(op, pick_size(op), 8'($urandom));
    end
    start_i <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Issued %0d commands of all eight operations, %0d results checked.",
             issued, results);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/av1ser_pkg.sv
rtl/core/av1ser_ram.sv
rtl/core/av1_syntax_element_reader_unit.sv
tb/av1ser_checker.sv
tb/testbench.sv
